// File: hw/rtl/primality_test_64bit_top_defines.svh
// assertion macros for the primality test block
// used by files that carry concurrent assertions
`ifndef PRIMALITY_TEST_64BIT_TOP_DEFINES_SVH
`define PRIMALITY_TEST_64BIT_TOP_DEFINES_SVH
// implication checked on every clock edge out of reset
`define PT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication out of reset
`define PT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/ptest_pkg.sv
// shared types and constants for the primality test block
// no dependencies
package ptest_pkg;
    localparam int NUM_BASES = 12;
    localparam int BASE_IDX_W = 4;
    localparam int BASE_W = 6;

    function automatic logic [BASE_W-1:0] base_value(input logic [BASE_IDX_W-1:0] idx);
        logic [BASE_W-1:0] v;
        begin
            case (idx)
                4'd0: v = 6'd2;
                4'd1: v = 6'd3;
                4'd2: v = 6'd5;
                4'd3: v = 6'd7;
                4'd4: v = 6'd11;
                4'd5: v = 6'd13;
                4'd6: v = 6'd17;
                4'd7: v = 6'd19;
                4'd8: v = 6'd23;
                4'd9: v = 6'd29;
                4'd10: v = 6'd31;
                4'd11: v = 6'd37;
                default: v = 6'd2;
            endcase
            return v;
        end
    endfunction

    typedef struct packed {
        logic go;
        logic busy;
        logic done;
    } mm_ctrl_t;
endpackage

// File: hw/rtl/ptest_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle (double and add)
// depends on ptest_pkg and the assertion macro header
`include "primality_test_64bit_top_defines.svh"
module ptest_mulmod #(
    parameter int WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [WIDTH-1:0]    a,
    input  logic [WIDTH-1:0]    b,
    input  logic [WIDTH-1:0]    n,
    output ptest_pkg::mm_ctrl_t ctrl,
    output logic [WIDTH-1:0]    r
);
    import ptest_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   dbl, dbl_red, add, add_red;

    always_comb
    begin
        dbl = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
        add = dbl_red + {1'b0, a};
        add_red = (add >= {1'b0, n}) ? add - {1'b0, n} : add;
        r_next = r_reg;
        b_next = b_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go && !busy_reg)
        begin
            r_next = '0;
            b_next = b;
            cnt_next = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next = b_reg[WIDTH-1] ? add_red[WIDTH-1:0] : dbl_red[WIDTH-1:0];
            b_next = {b_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign r = r_reg;
    assign ctrl.go = go;
    assign ctrl.busy = busy_reg;
    assign ctrl.done = done_reg;

    `PT_ASSERT_IMPL(a_done_idle, done_reg, !busy_reg)
    `PT_ASSERT_NEXT(a_go_busy, go && !busy_reg, busy_reg)
    `PT_ASSERT_IMPL(a_cnt_zero, !busy_reg, cnt_reg == '0)
endmodule

// File: hw/rtl/primality_test_64bit_top.sv
// top level of the deterministic 64-bit primality test
// depends on ptest_pkg, ptest_mulmod and the assertion macro header
//
// usage: drive candidate and pulse start while busy is low; the item is
// taken at that edge and busy rises. one item at a time; a new item may
// be taken at the edge that ends the done cycle.
// the answer appears on prime_flag with done high for exactly one cycle,
// and busy drops in that same cycle. the receiver cannot stall.
// processing: trivial candidates (0, 1, 2, even) go from S_CHECK straight to
// S_FINISH. others run up to twelve bases; each base first reduces the base
// mod n by repeated subtraction, then computes base^d mod n (one multiply
// per set bit of d plus one square per bit) and up to s-1 squarings. every
// modular multiply is bit-serial in ptest_mulmod, and all of them run on
// the single shared multiplier.
// reset clears all control state; nothing is pending after reset.
`include "primality_test_64bit_top_defines.svh"
module primality_test_64bit_top #(
    parameter int WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] candidate,
    output logic        busy,
    output logic        done,
    output logic        prime_flag
);
    import ptest_pkg::*;

    localparam int SW = $clog2(WIDTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SPLIT, S_BASE, S_REDUCE, S_EXP_BIT, S_EXP_MUL, S_EXP_SQ,
        S_EVAL, S_SQ, S_SQ_EVAL, S_FINISH
    } state_t;

    state_t               state_reg;
    logic [WIDTH-1:0]     n_reg, d_reg, e_reg, acc_reg, b_reg;
    logic [SW-1:0]        s_reg, i_reg;
    logic [BASE_IDX_W-1:0] k_reg;
    logic                 pend_reg;
    logic                 done_reg, flag_reg;
    logic                 mm_go_reg;
    logic [WIDTH-1:0]     mm_a_reg, mm_b_reg;
    mm_ctrl_t             mm_ctrl;
    logic [WIDTH-1:0]     mm_r;
    logic [WIDTH-1:0]     nm1, base_w;

    assign nm1 = n_reg - 1'b1;
    assign base_w = WIDTH'(base_value(k_reg));

    ptest_mulmod #(.WIDTH(WIDTH)) u_mm (
        .clk(clk), .rst_n(rst_n), .go(mm_go_reg),
        .a(mm_a_reg), .b(mm_b_reg), .n(n_reg),
        .ctrl(mm_ctrl), .r(mm_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            flag_reg <= 1'b0;
            mm_go_reg <= 1'b0;
            pend_reg <= 1'b0;
            k_reg <= '0;
            s_reg <= '0;
            i_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            mm_go_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        n_reg <= candidate[WIDTH-1:0];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (n_reg <= WIDTH'(1) || (!n_reg[0] && n_reg != WIDTH'(2)))
                    begin
                        flag_reg <= 1'b0;
                        state_reg <= S_FINISH;
                    end
                    else if (n_reg == WIDTH'(2))
                    begin
                        flag_reg <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        d_reg <= nm1;
                        s_reg <= '0;
                        k_reg <= '0;
                        state_reg <= S_SPLIT;
                    end
                end
                S_SPLIT:
                begin
                    if (!d_reg[0])
                    begin
                        d_reg <= d_reg >> 1;
                        s_reg <= s_reg + 1'b1;
                    end
                    else
                        state_reg <= S_BASE;
                end
                S_BASE:
                begin
                    if (k_reg == BASE_IDX_W'(NUM_BASES))
                    begin
                        flag_reg <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        b_reg <= base_w;
                        state_reg <= S_REDUCE;
                    end
                end
                S_REDUCE:
                begin
                    // base mod n by repeated subtraction; a multiple of n passes
                    if (b_reg >= n_reg)
                        b_reg <= b_reg - n_reg;
                    else if (b_reg == '0)
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_BASE;
                    end
                    else
                    begin
                        acc_reg <= WIDTH'(1);
                        e_reg <= d_reg;
                        state_reg <= S_EXP_BIT;
                    end
                end
                S_EXP_BIT:
                begin
                    if (e_reg == '0)
                        state_reg <= S_EVAL;
                    else if (e_reg[0])
                    begin
                        mm_a_reg <= acc_reg;
                        mm_b_reg <= b_reg;
                        mm_go_reg <= 1'b1;
                        pend_reg <= 1'b1;
                        state_reg <= S_EXP_MUL;
                    end
                    else
                    begin
                        mm_a_reg <= b_reg;
                        mm_b_reg <= b_reg;
                        mm_go_reg <= 1'b1;
                        pend_reg <= 1'b1;
                        state_reg <= S_EXP_SQ;
                    end
                end
                S_EXP_MUL:
                begin
                    if (mm_ctrl.done)
                    begin
                        acc_reg <= mm_r;
                        mm_a_reg <= b_reg;
                        mm_b_reg <= b_reg;
                        mm_go_reg <= 1'b1;
                        state_reg <= S_EXP_SQ;
                    end
                end
                S_EXP_SQ:
                begin
                    if (mm_ctrl.done)
                    begin
                        b_reg <= mm_r;
                        e_reg <= e_reg >> 1;
                        pend_reg <= 1'b0;
                        state_reg <= S_EXP_BIT;
                    end
                end
                S_EVAL:
                begin
                    i_reg <= SW'(1);
                    if (acc_reg == WIDTH'(1) || acc_reg == nm1)
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_BASE;
                    end
                    else
                        state_reg <= S_SQ_EVAL;
                end
                S_SQ_EVAL:
                begin
                    if (i_reg >= s_reg)
                    begin
                        flag_reg <= 1'b0;
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        mm_a_reg <= acc_reg;
                        mm_b_reg <= acc_reg;
                        mm_go_reg <= 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (mm_ctrl.done)
                    begin
                        acc_reg <= mm_r;
                        i_reg <= i_reg + 1'b1;
                        if (mm_r == nm1)
                        begin
                            k_reg <= k_reg + 1'b1;
                            state_reg <= S_BASE;
                        end
                        else if (mm_r == WIDTH'(1))
                        begin
                            flag_reg <= 1'b0;
                            state_reg <= S_FINISH;
                        end
                        else
                            state_reg <= S_SQ_EVAL;
                    end
                end
                S_FINISH:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign prime_flag = flag_reg;

    `PT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `PT_ASSERT_IMPL(a_done_idle, done_reg, !busy)
    `PT_ASSERT_IMPL(a_mm_no_overlap, mm_go_reg, !mm_ctrl.busy)
    `PT_ASSERT_IMPL(a_exp_pend, state_reg == S_EXP_SQ, pend_reg)
endmodule

// File: test/primality_test_64bit_top_tb.sv
// testbench for primality_test_64bit_top: drives candidates, predicts the prime flag
// with a strong probable-prime test over twelve small bases, checks each answer
// depends on primality_test_64bit_top only
module primality_test_64bit_top_tb;

    localparam int WIDTH = 64;
    localparam int IDLE_LIMIT = 400000;

    class prime_scoreboard;
        bit expected_flags[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void note_item(bit flag);
            expected_flags.push_back(flag);
        endfunction

        task check_flag(logic flag);
            bit want;
            if (expected_flags.size() == 0)
            begin
                report_mismatch("answer with no item waiting");
                return;
            end
            want = expected_flags.pop_front();
            if (flag !== want)
                report_mismatch($sformatf("prime_flag %b, expected %b", flag, want));
        endtask

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [63:0] candidate;
    logic        busy;
    logic        done;
    logic        prime_flag;

    prime_scoreboard board;
    int          idle_cycles;

    primality_test_64bit_top #(.WIDTH(WIDTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .candidate(candidate),
        .busy(busy),
        .done(done),
        .prime_flag(prime_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // exact modular product
    function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, n});
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] b, logic [63:0] e, logic [63:0] n);
        logic [63:0] acc;
        acc = 64'd1;
        b = b % n;
        while (e != 0)
        begin
            if (e[0])
                acc = mod_mul(acc, b, n);
            b = mod_mul(b, b, n);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic bit passes_base(logic [63:0] a, logic [63:0] n);
        logic [63:0] nm1;
        logic [63:0] d;
        logic [63:0] x;
        int s;
        nm1 = n - 1;
        d = nm1;
        s = 0;
        if (a % n == 0)
            return 1'b1;
        while (d[0] == 1'b0)
        begin
            d = d >> 1;
            s++;
        end
        x = mod_pow(a, d, n);
        if (x == 1 || x == nm1)
            return 1'b1;
        for (int i = 1; i < s; i++)
        begin
            x = mod_mul(x, x, n);
            if (x == nm1)
                return 1'b1;
            if (x == 1)
                return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic bit predict_flag(logic [63:0] raw);
        logic [63:0] n;
        int bases[12];
        bases = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
        n = (WIDTH >= 64) ? raw : (raw & ((64'd1 << WIDTH) - 1));
        if (n <= 1)
            return 1'b0;
        if (n == 2)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        foreach (bases[k])
            if (!passes_base(64'(bases[k]), n))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(logic [63:0] value);
        int gap;
        gap = $urandom_range(0, 8);
        repeat (gap) @(posedge clk);
        start <= 1'b1;
        candidate <= value;
        do
            @(posedge clk);
        while (busy);
        board.note_item(predict_flag(value));
        start <= 1'b0;
        candidate <= {$urandom, $urandom};
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (board.expected_flags.size() != 0)
            @(posedge clk);
    endtask

    // random prime-ish or composite candidates, mostly odd
    function automatic logic [63:0] random_candidate();
        logic [63:0] v;
        int kind;
        int sh;
        kind = $urandom_range(0, 9);
        sh = $urandom_range(0, 63);
        v = {$urandom, $urandom} >> sh;
        case (kind)
            0: v = v & 64'hFFFF;
            1: v = 64'(mod_mul(v | 1, 64'd0 + $urandom_range(3, 1000), 64'hFFFF_FFFF_FFFF_FFFF));
            9: v = v;
            default: v = v | 64'd1;
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_flag(prime_flag);
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("primality_test_64bit_top test failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] directed[$];
        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        candidate = 64'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd37, 64'd41, 64'd561,
                     64'd3215031751, 64'd341550071728321, 64'hFFFF_FFFF_FFFF_FFC5,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                     64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                     64'd3825123056546413051, 64'd18446744073709551557,
                     64'd1000000007, 64'd25, 64'd49};
        foreach (directed[i])
            send_item(directed[i]);
        wait_drained();
        for (int i = 0; i < 80; i++)
        begin
            send_item(random_candidate());
            if (i == 40)
                wait_drained();
        end
        wait_drained();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("primality_test_64bit_top test passed");
        else
            $display("primality_test_64bit_top test failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ptest_pkg.sv
hw/rtl/ptest_mulmod.sv
hw/rtl/primality_test_64bit_top.sv
test/primality_test_64bit_top_tb.sv
